@@ hw/rtl/clp_pkg.sv @@
// Shared types and constants for the homogeneous line clipper.
// Used by clp_div_cell, clp_lerp and homogeneous_line_clipper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

  localparam int CW     = 32;      // coordinate width, signed Q16.16
  localparam int CHW    = 8;       // one color channel
  localparam int NCH    = 3;       // color channels per end
  localparam int NCRD   = 4;       // x, y, z, w
  localparam int PLANES = 6;
  localparam int TW     = 32;      // clip parameter fraction bits
  localparam int BW     = CW + 1;  // boundary value width
  localparam int DW     = CW + 2;  // divider operand width

  localparam logic [TW:0] T_ONE = {1'b1, {TW{1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0]  first_x;
    logic signed [CW-1:0]  first_y;
    logic signed [CW-1:0]  first_z;
    logic signed [CW-1:0]  first_w;
    logic [NCH*CHW-1:0]    first_color;
    logic signed [CW-1:0]  second_x;
    logic signed [CW-1:0]  second_y;
    logic signed [CW-1:0]  second_z;
    logic signed [CW-1:0]  second_w;
    logic [NCH*CHW-1:0]    second_color;
  } clp_in_t;

  typedef struct packed {
    logic signed [CW-1:0]  start_x;
    logic signed [CW-1:0]  start_y;
    logic signed [CW-1:0]  start_z;
    logic signed [CW-1:0]  start_w;
    logic [NCH*CHW-1:0]    start_color;
    logic signed [CW-1:0]  end_x;
    logic signed [CW-1:0]  end_y;
    logic signed [CW-1:0]  end_z;
    logic signed [CW-1:0]  end_w;
    logic [NCH*CHW-1:0]    end_color;
  } clp_out_t;

  // One divider stage's worth of state: six restoring divisions in flight
  // plus everything the later stages need about the segment.
  typedef struct packed {
    logic [PLANES-1:0][DW-1:0] rem;
    logic [PLANES-1:0][DW-1:0] den;
    logic [PLANES-1:0][TW-1:0] quo;
    logic [PLANES-1:0]         sel_in;
    logic [PLANES-1:0]         sel_out;
    logic [PLANES-1:0]         acode;
    logic [PLANES-1:0]         ccode;
    clp_in_t                   seg;
  } clp_div_t;

endpackage

`default_nettype wire

@@ hw/rtl/homogeneous_line_clipper.sv @@
// 39 pipeline stages: boundary, setup, 32 divider cells, select and four lerp stages.
// Throughput: one item per cycle while out_stall is low, set by the 32-cell divider chain (one quotient bit per cell).
// Holes in the pipeline close up, so the input keeps taking items while a result waits.
// Reset (synchronous, rst_n low) clears only the valid bits; datapath registers are not reset.
// Depends on clp_pkg, clp_div_cell and clp_lerp.
`timescale 1ns / 1ps
`default_nettype none

module homogeneous_line_clipper (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire clp_pkg::clp_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output clp_pkg::clp_out_t     out_data
);

  localparam int PLANES = clp_pkg::PLANES;
  localparam int BW     = clp_pkg::BW;
  localparam int DW     = clp_pkg::DW;
  localparam int TW     = clp_pkg::TW;
  localparam int CW     = clp_pkg::CW;
  localparam int CHW    = clp_pkg::CHW;
  localparam int NCELLS = clp_pkg::TW;
  // Boundary stage, setup stage, divider cells, select stage, four lerp stages.
  localparam int NST    = NCELLS + 7;
  localparam int SEL    = NCELLS + 2;
  localparam int L0     = NCELLS + 3;

  function automatic logic [BW-1:0] sx(input logic [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic [DW-1:0] sxd(input logic [BW-1:0] v);
    return {v[BW-1], v};
  endfunction

  // Flow control: a stage may load when it is empty or its successor loads.
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // Boundary stage: the six values w+x, w-x, w+y, w-y, w+z, w-z for each end.
  logic                             b0_vld_r;
  clp_pkg::clp_in_t                 b0_seg_r;
  logic [PLANES-1:0][BW-1:0]        ab_nxt, cb_nxt, b0_ab_r, b0_cb_r;

  always_comb begin
    ab_nxt[0] = sx(in_data.first_w) + sx(in_data.first_x);
    ab_nxt[1] = sx(in_data.first_w) - sx(in_data.first_x);
    ab_nxt[2] = sx(in_data.first_w) + sx(in_data.first_y);
    ab_nxt[3] = sx(in_data.first_w) - sx(in_data.first_y);
    ab_nxt[4] = sx(in_data.first_w) + sx(in_data.first_z);
    ab_nxt[5] = sx(in_data.first_w) - sx(in_data.first_z);
    cb_nxt[0] = sx(in_data.second_w) + sx(in_data.second_x);
    cb_nxt[1] = sx(in_data.second_w) - sx(in_data.second_x);
    cb_nxt[2] = sx(in_data.second_w) + sx(in_data.second_y);
    cb_nxt[3] = sx(in_data.second_w) - sx(in_data.second_y);
    cb_nxt[4] = sx(in_data.second_w) + sx(in_data.second_z);
    cb_nxt[5] = sx(in_data.second_w) - sx(in_data.second_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r <= 1'b0;
    end else if (rdy[0]) begin
      b0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      b0_seg_r <= in_data;
      b0_ab_r  <= ab_nxt;
      b0_cb_r  <= cb_nxt;
    end
  end

  // Setup stage: outcodes, and for each plane the division that it needs.
  // A plane the second end leaves bounds the exit with ab / (ab - cb); a plane
  // the first end lies behind bounds the entry with -ab / (cb - ab). A value of
  // exactly zero sets the outcode bit but counts as inside when the division is chosen.
  logic             b1_vld_r;
  clp_pkg::clp_div_t b1_nxt, b1_r;

  always_comb begin
    b1_nxt     = '0;
    b1_nxt.seg = b0_seg_r;
    for (int i = 0; i < PLANES; i++) begin
      b1_nxt.acode[i]   = b0_ab_r[i][BW-1] || (b0_ab_r[i] == '0);
      b1_nxt.ccode[i]   = b0_cb_r[i][BW-1] || (b0_cb_r[i] == '0);
      b1_nxt.sel_out[i] = b0_cb_r[i][BW-1];
      b1_nxt.sel_in[i]  = !b0_cb_r[i][BW-1] && b0_ab_r[i][BW-1];
      if (b0_cb_r[i][BW-1]) begin
        b1_nxt.rem[i] = sxd(b0_ab_r[i]);
        b1_nxt.den[i] = sxd(b0_ab_r[i]) - sxd(b0_cb_r[i]);
      end else begin
        b1_nxt.rem[i] = DW'(0) - sxd(b0_ab_r[i]);
        b1_nxt.den[i] = sxd(b0_cb_r[i]) - sxd(b0_ab_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else if (rdy[1]) begin
      b1_vld_r <= b0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b1_r <= b1_nxt;
    end
  end

  // Divider chain: each cell adds one quotient bit to all six divisions.
  logic [NCELLS:0]   dv;
  clp_pkg::clp_div_t dd [NCELLS+1];

  assign dv[0] = b1_vld_r;
  assign dd[0] = b1_r;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    clp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (rdy[k+2]),
      .vld_in  (dv[k]),
      .data_in (dd[k]),
      .vld_r   (dv[k+1]),
      .data_r  (dd[k+1])
    );
  end

  // Select stage: entry is the largest entering parameter, exit the smallest
  // leaving one. Since the entry only grows and the exit only shrinks, the
  // empty-interval test on the final pair catches every early reject. Both
  // ends outside one plane drops the item here too.
  logic              sel_vld_r, sel_sa_r, sel_se_r;
  clp_pkg::clp_in_t  sel_seg_r;
  logic [TW:0]       tin, tout, sel_tin_r, sel_tout_r;
  logic              keep;
  clp_pkg::clp_div_t dl;

  always_comb begin
    dl   = dd[NCELLS];
    tin  = '0;
    tout = clp_pkg::T_ONE;
    for (int i = 0; i < PLANES; i++) begin
      if (dl.sel_out[i] && ({1'b0, dl.quo[i]} < tout)) begin
        tout = {1'b0, dl.quo[i]};
      end else if (dl.sel_in[i] && ({1'b0, dl.quo[i]} > tin)) begin
        tin = {1'b0, dl.quo[i]};
      end
    end
    keep = ((dl.acode & dl.ccode) == '0) &&
           (((dl.acode | dl.ccode) == '0) || (tin <= tout));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else if (rdy[SEL]) begin
      sel_vld_r <= dv[NCELLS] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[SEL]) begin
      sel_seg_r  <= dl.seg;
      sel_tin_r  <= tin;
      sel_tout_r <= tout;
      sel_sa_r   <= (dl.acode != '0);
      sel_se_r   <= (dl.ccode != '0);
    end
  end

  // Interpolation lanes: four coordinates and three color channels per end.
  logic [3:0] lv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else begin
      if (rdy[L0])   lv_r[0] <= sel_vld_r;
      if (rdy[L0+1]) lv_r[1] <= lv_r[0];
      if (rdy[L0+2]) lv_r[2] <= lv_r[1];
      if (rdy[L0+3]) lv_r[3] <= lv_r[2];
    end
  end

  assign vld[0]            = b0_vld_r;
  assign vld[1]            = b1_vld_r;
  assign vld[NCELLS+1:2]   = dv[NCELLS:1];
  assign vld[SEL]          = sel_vld_r;
  assign vld[NST-1:L0]     = lv_r;
  assign out_valid         = lv_r[3];

  logic [3:0] len;
  assign len = rdy[NST-1:L0];

  logic [clp_pkg::NCRD-1:0][CW-1:0] cf, cs, rs, re;
  logic [clp_pkg::NCH*CHW-1:0]      cols, cole;

  assign cf = {sel_seg_r.first_w, sel_seg_r.first_z, sel_seg_r.first_y, sel_seg_r.first_x};
  assign cs = {sel_seg_r.second_w, sel_seg_r.second_z, sel_seg_r.second_y,
               sel_seg_r.second_x};

  for (genvar g = 0; g < clp_pkg::NCRD; g++) begin : g_crd
    clp_lerp #(.VW(CW), .SGN(1'b1)) u_start (
      .clk (clk), .en (len), .p (cf[g]), .q (cs[g]), .pass (cf[g]),
      .t (sel_tin_r), .sel (sel_sa_r), .res_r (rs[g])
    );
    clp_lerp #(.VW(CW), .SGN(1'b1)) u_end (
      .clk (clk), .en (len), .p (cf[g]), .q (cs[g]), .pass (cs[g]),
      .t (sel_tout_r), .sel (sel_se_r), .res_r (re[g])
    );
  end

  for (genvar g = 0; g < clp_pkg::NCH; g++) begin : g_col
    clp_lerp #(.VW(CHW), .SGN(1'b0)) u_start (
      .clk (clk), .en (len),
      .p (sel_seg_r.first_color[g*CHW +: CHW]),
      .q (sel_seg_r.second_color[g*CHW +: CHW]),
      .pass (sel_seg_r.first_color[g*CHW +: CHW]),
      .t (sel_tin_r), .sel (sel_sa_r), .res_r (cols[g*CHW +: CHW])
    );
    clp_lerp #(.VW(CHW), .SGN(1'b0)) u_end (
      .clk (clk), .en (len),
      .p (sel_seg_r.first_color[g*CHW +: CHW]),
      .q (sel_seg_r.second_color[g*CHW +: CHW]),
      .pass (sel_seg_r.second_color[g*CHW +: CHW]),
      .t (sel_tout_r), .sel (sel_se_r), .res_r (cole[g*CHW +: CHW])
    );
  end

  always_comb begin
    out_data.start_x     = rs[0];
    out_data.start_y     = rs[1];
    out_data.start_z     = rs[2];
    out_data.start_w     = rs[3];
    out_data.start_color = cols;
    out_data.end_x       = re[0];
    out_data.end_y       = re[1];
    out_data.end_z       = re[2];
    out_data.end_w       = re[3];
    out_data.end_color   = cole;
  end

  // The input only stalls when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld))
    else $error("input stalled with an empty pipeline stage");

  // A segment that survives selection has a non-empty parameter interval.
  a_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_vld_r && (sel_sa_r || sel_se_r)) |-> (sel_tin_r <= sel_tout_r))
    else $error("kept segment with entry beyond exit");

  // No exit parameter exceeds one.
  a_tmax: assert property (@(posedge clk) disable iff (!rst_n)
    sel_vld_r |-> (!sel_tout_r[TW] || (sel_tout_r[TW-1:0] == '0)))
    else $error("exit parameter above one");

endmodule

`default_nettype wire

@@ hw/rtl/clp_div_cell.sv @@
// One cell of the divider chain: one restoring quotient bit for all six planes.
// Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_in,
  input  wire clp_pkg::clp_div_t data_in,
  output logic                   vld_r,
  output clp_pkg::clp_div_t      data_r
);

  clp_pkg::clp_div_t                                 data_nxt;
  logic [clp_pkg::PLANES-1:0][clp_pkg::DW-1:0]       shf;
  logic [clp_pkg::PLANES-1:0]                        ge;

  always_comb begin
    data_nxt = data_in;
    for (int i = 0; i < clp_pkg::PLANES; i++) begin
      shf[i] = {data_in.rem[i][clp_pkg::DW-2:0], 1'b0};
      ge[i]  = (shf[i] >= data_in.den[i]);
      data_nxt.rem[i] = ge[i] ? (shf[i] - data_in.den[i]) : shf[i];
      data_nxt.quo[i] = {data_in.quo[i][clp_pkg::TW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/clp_lerp.sv @@
// Four-stage interpolation lane: p + round(t * (q - p)), or a pass value.
// Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_lerp #(
  parameter int VW  = clp_pkg::CW,
  parameter bit SGN = 1'b1
) (
  input  wire logic                 clk,
  input  wire logic [3:0]           en,
  input  wire logic [VW-1:0]        p,
  input  wire logic [VW-1:0]        q,
  input  wire logic [VW-1:0]        pass,
  input  wire logic [clp_pkg::TW:0] t,
  input  wire logic                 sel,
  output logic [VW-1:0]             res_r
);

  localparam int TW = clp_pkg::TW;
  localparam int DW = VW + 1;
  localparam int HW = (DW > TW) ? (DW - TW) : 1;
  localparam int MW = TW + HW;
  localparam logic [2*TW:0] HALF = (2*TW+1)'(1) << (TW - 1);

  logic [DW-1:0]      diff;
  logic [DW-1:0]      mag;
  logic [2*TW:0]      lowsum;
  logic [HW+TW:0]     rnd;
  logic [DW-1:0]      sum;
  logic [VW-1:0]      res_nxt;

  logic               neg0_r, neg1_r, neg2_r;
  logic [MW-1:0]      mag0_r;
  logic [VW-1:0]      p0_r, p1_r, p2_r;
  logic [VW-1:0]      pass0_r, pass1_r, pass2_r;
  logic               sel0_r, sel1_r, sel2_r;
  logic [TW:0]        t0_r;
  logic [2*TW-1:0]    plo1_r;
  logic [HW+TW-1:0]   phi1_r;
  logic [DW-1:0]      rnd2_r;

  always_comb begin
    diff    = {SGN & q[VW-1], q} - {SGN & p[VW-1], p};
    mag     = diff[DW-1] ? (DW'(0) - diff) : diff;
    lowsum  = {1'b0, plo1_r} + HALF;
    rnd     = {1'b0, phi1_r} + (HW+TW+1)'(lowsum[2*TW:TW]);
    sum     = neg2_r ? ({SGN & p2_r[VW-1], p2_r} - rnd2_r)
                     : ({SGN & p2_r[VW-1], p2_r} + rnd2_r);
    res_nxt = sel2_r ? sum[VW-1:0] : pass2_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0_r  <= diff[DW-1];
      mag0_r  <= MW'(mag);
      p0_r    <= p;
      pass0_r <= pass;
      sel0_r  <= sel;
      t0_r    <= t;
    end
    if (en[1]) begin
      // A parameter of exactly one moves the whole distance.
      if (t0_r[TW]) begin
        plo1_r <= {mag0_r[TW-1:0], {TW{1'b0}}};
        phi1_r <= {mag0_r[MW-1:TW], {TW{1'b0}}};
      end else begin
        plo1_r <= mag0_r[TW-1:0] * t0_r[TW-1:0];
        phi1_r <= mag0_r[MW-1:TW] * t0_r[TW-1:0];
      end
      neg1_r  <= neg0_r;
      p1_r    <= p0_r;
      pass1_r <= pass0_r;
      sel1_r  <= sel0_r;
    end
    if (en[2]) begin
      rnd2_r  <= rnd[DW-1:0];
      neg2_r  <= neg1_r;
      p2_r    <= p1_r;
      pass2_r <= pass1_r;
      sel2_r  <= sel1_r;
    end
    if (en[3]) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
